/* rtl/core/wind_beacon_frame_builder_macros.svh */
// ---------------------------------------------------------------------------
// wind_beacon_frame_builder assertion macros
// concurrent assertion helpers clocked on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef WIND_BEACON_FRAME_BUILDER_MACROS_SVH
`define WIND_BEACON_FRAME_BUILDER_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define WB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define WB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WB_ASSERT_IMPL(lbl, ante, cons)
`define WB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/core/wbfb_pkg.sv */
// ---------------------------------------------------------------------------
// wbfb_pkg
// shared types, frame constants and the byte layout of the advertisement
// ---------------------------------------------------------------------------
package wbfb_pkg;

  localparam int unsigned FRAME_LEN = 31;
  localparam int unsigned PROD_W    = 56;

  localparam logic [4:0] LAST_IDX = 5'(FRAME_LEN - 1);
  localparam logic [4:0] NAME_IDX = 5'd20;

  // register indexes
  localparam logic [1:0] REG_TICK      = 2'd0;
  localparam logic [1:0] REG_HEARTBEAT = 2'd1;
  localparam logic [1:0] REG_SCALE     = 2'd2;

  // fixed header bytes
  localparam logic [7:0] AD_FLAGS_LEN  = 8'h02;
  localparam logic [7:0] AD_FLAGS_TYPE = 8'h01;
  localparam logic [7:0] AD_FLAGS_VAL  = 8'h06;
  localparam logic [7:0] AD_SVC_LEN    = 8'h0E;
  localparam logic [7:0] AD_SVC_TYPE   = 8'h16;
  localparam logic [7:0] UUID_LO       = 8'hD2;
  localparam logic [7:0] UUID_HI       = 8'hFC;
  localparam logic [7:0] DEV_INFO      = 8'h40;
  localparam logic [7:0] OBJ_PID       = 8'h00;
  localparam logic [7:0] OBJ_BATT      = 8'h01;
  localparam logic [7:0] OBJ_TEMP      = 8'h02;
  localparam logic [7:0] OBJ_SPEED     = 8'h44;
  localparam logic [7:0] NAME_LEN      = 8'h0C;
  localparam logic [7:0] NAME_TYPE     = 8'h09;

  localparam logic [7:0] NAME_BYTES [11] = '{
    8'h57, 8'h69, 8'h6E, 8'h64, 8'h20, 8'h53, 8'h65, 8'h6E, 8'h73, 8'h6F, 8'h72
  };

  typedef struct packed {
    logic [7:0]        seq_num;
    logic [6:0]        battery;
    logic [15:0]       temp;
    logic [PROD_W-1:0] product;
  } frame_t;

  function automatic logic [7:0] frame_byte_at(input logic [4:0] idx,
                                               input frame_t fr,
                                               input logic [15:0] speed);
    logic [4:0] nidx;
    logic [7:0] b;
    nidx = idx - NAME_IDX;
    case (idx)
      5'd0:  b = AD_FLAGS_LEN;
      5'd1:  b = AD_FLAGS_TYPE;
      5'd2:  b = AD_FLAGS_VAL;
      5'd3:  b = AD_SVC_LEN;
      5'd4:  b = AD_SVC_TYPE;
      5'd5:  b = UUID_LO;
      5'd6:  b = UUID_HI;
      5'd7:  b = DEV_INFO;
      5'd8:  b = OBJ_PID;
      5'd9:  b = fr.seq_num;
      5'd10: b = OBJ_BATT;
      5'd11: b = {1'b0, fr.battery};
      5'd12: b = OBJ_TEMP;
      5'd13: b = fr.temp[7:0];
      5'd14: b = fr.temp[15:8];
      5'd15: b = OBJ_SPEED;
      5'd16: b = speed[7:0];
      5'd17: b = speed[15:8];
      5'd18: b = NAME_LEN;
      5'd19: b = NAME_TYPE;
      default: begin
        if (idx inside {[NAME_IDX:LAST_IDX]}) begin
          b = NAME_BYTES[nidx[3:0]];
        end else begin
          b = 8'h00;
        end
      end
    endcase
    return b;
  endfunction

endpackage

/* rtl/core/wbfb_eval.sv */
// ---------------------------------------------------------------------------
// wbfb_eval
// tick evaluation: heartbeat timer, pulse delta, advertise decision, speed product
// ---------------------------------------------------------------------------
module wbfb_eval (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic [31:0]                 pulse_count,
  input  logic [6:0]                  batt_level,
  input  logic [15:0]                 temp_centi,
  input  logic [11:0]                 tick_seconds,
  input  logic [15:0]                 heartbeat_seconds,
  input  logic [23:0]                 speed_scale,
  output logic                        emit,
  output wbfb_pkg::frame_t            frame
);

  logic        primed_r,  primed_nxt;
  logic [31:0] base_r,    base_nxt;
  logic [16:0] elapsed_r, elapsed_nxt;
  logic [31:0] sent_r,    sent_nxt;
  logic [7:0]  pid_r,     pid_nxt;

  logic [31:0] base_eff;
  logic [16:0] elapsed_eff;
  logic [16:0] elapsed_sum;
  logic [31:0] sent_eff;
  logic [7:0]  pid_eff;
  logic [31:0] delta;

  always_comb begin
    // first tick takes the baseline and clears the history
    base_eff    = primed_r ? base_r    : pulse_count;
    elapsed_eff = primed_r ? elapsed_r : 17'd0;
    sent_eff    = primed_r ? sent_r    : 32'd0;
    pid_eff     = primed_r ? pid_r     : 8'd0;

    elapsed_sum = elapsed_eff + {5'd0, tick_seconds};
    delta       = pulse_count - base_eff;
    emit        = (delta != sent_eff) || (elapsed_sum >= {1'b0, heartbeat_seconds});

    frame.seq_num = pid_eff;
    frame.battery = batt_level;
    frame.temp    = temp_centi;
    frame.product = 56'(delta) * 56'(speed_scale);
  end

  always_comb begin
    primed_nxt  = primed_r;
    base_nxt    = base_r;
    elapsed_nxt = elapsed_r;
    sent_nxt    = sent_r;
    pid_nxt     = pid_r;
    if (take) begin
      primed_nxt = 1'b1;
      if (emit) begin
        base_nxt    = pulse_count;
        elapsed_nxt = 17'd0;
        sent_nxt    = delta;
        pid_nxt     = pid_eff + 8'd1;
      end else begin
        base_nxt    = base_eff;
        elapsed_nxt = elapsed_sum;
        sent_nxt    = sent_eff;
        pid_nxt     = pid_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r  <= 1'b0;
      base_r    <= 32'd0;
      elapsed_r <= 17'd0;
      sent_r    <= 32'd0;
      pid_r     <= 8'd0;
    end else begin
      primed_r  <= primed_nxt;
      base_r    <= base_nxt;
      elapsed_r <= elapsed_nxt;
      sent_r    <= sent_nxt;
      pid_r     <= pid_nxt;
    end
  end

endmodule

/* rtl/core/wbfb_serializer.sv */
// ---------------------------------------------------------------------------
// wbfb_serializer
// holds one evaluated frame and streams its 31 bytes, one per transfer
// ---------------------------------------------------------------------------
`include "wind_beacon_frame_builder_macros.svh"

module wbfb_serializer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  wbfb_pkg::frame_t frame,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       frame_byte,
  output logic [4:0]       byte_index,
  output logic             last_byte
);

  logic             busy_r, busy_nxt;
  logic [4:0]       idx_r,  idx_nxt;
  wbfb_pkg::frame_t fr_r;

  logic                    xfer;
  logic [wbfb_pkg::PROD_W:0] rounded;
  logic [15:0]             speed;

  always_comb begin
    xfer     = busy_r && out_ready;
    can_load = !busy_r || (xfer && (idx_r == wbfb_pkg::LAST_IDX));

    // round half up, saturate to 16 bits
    rounded = {1'b0, fr_r.product} + (wbfb_pkg::PROD_W + 1)'(32768);
    speed   = (|rounded[wbfb_pkg::PROD_W:32]) ? 16'hFFFF : rounded[31:16];

    out_valid  = busy_r;
    byte_index = idx_r;
    last_byte  = busy_r && (idx_r == wbfb_pkg::LAST_IDX);
    frame_byte = wbfb_pkg::frame_byte_at(idx_r, fr_r, speed);
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (xfer) begin
      if (idx_r == wbfb_pkg::LAST_IDX) begin
        busy_nxt = 1'b0;
        idx_nxt  = 5'd0;
      end else begin
        idx_nxt = idx_r + 5'd1;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fr_r <= frame;
    end
  end

  `WB_ASSERT_IMPL(a_idx_range, busy_r, idx_r <= wbfb_pkg::LAST_IDX)
  `WB_ASSERT_NEXT(a_idx_step, xfer && (idx_r != wbfb_pkg::LAST_IDX) && !load,
                  busy_r && (idx_r == 5'($past(idx_r) + 5'd1)))
  `WB_ASSERT_IMPL(a_no_overrun, load,
                  !busy_r || (out_ready && idx_r == wbfb_pkg::LAST_IDX))

endmodule

/* rtl/core/wind_beacon_frame_builder.sv */
// ---------------------------------------------------------------------------
// wind_beacon_frame_builder
// wake-tick beacon encoder: decides per tick and streams a 31-byte advertisement
// ---------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries one wake tick: pulse counter,
//   battery level and temperature. the tick lands in an input register and
//   is evaluated once the byte serializer can take a frame.
//   an advertising tick produces 31 transfers on the output channel
//   (out_valid/out_ready), byte_index 0..30, last_byte on index 30.
//   the first byte appears once the tick has passed the input register and the
//   serializer's frame register; a tick that advertises nothing is retired
//   and produces no transfer. the serializer's single byte lane sets the frame
//   rate with out_ready held high; the next tick is taken while a frame
//   streams and is evaluated in the cycle the last byte transfers.
//   when the receiver stalls the current byte holds; one further tick is
//   buffered, then in_ready drops.
//   cfg_we writes register cfg_index (0 tick, 1 heartbeat, 2 scale) at once;
//   index 3 is ignored. write only while idle.
//   reset (synchronous, rst_n low) restores the register defaults, clears the
//   baseline and drops any frame in flight.
// ---------------------------------------------------------------------------
module wind_beacon_frame_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_pulse_count,
  input  logic [6:0]  in_batt_level,
  input  logic signed [15:0] in_temp_centi,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_frame_byte,
  output logic [4:0]  out_byte_index,
  output logic        out_last_byte
);

  logic [11:0] tick_r;
  logic [15:0] hb_r;
  logic [23:0] scale_r;

  logic        hold_r;
  logic [31:0] count_r;
  logic [6:0]  batt_r;
  logic [15:0] temp_r;

  logic             take;
  logic             emit;
  logic             can_load;
  wbfb_pkg::frame_t frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= 12'd5;
      hb_r    <= 16'd60;
      scale_r <= 24'd802960;
    end else if (cfg_we) begin
      case (cfg_index)
        wbfb_pkg::REG_TICK:      tick_r  <= cfg_data[11:0];
        wbfb_pkg::REG_HEARTBEAT: hb_r    <= cfg_data[15:0];
        wbfb_pkg::REG_SCALE:     scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign take     = hold_r && can_load;
  assign in_ready = !hold_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (in_ready) begin
      hold_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      count_r <= in_pulse_count;
      batt_r  <= in_batt_level;
      temp_r  <= in_temp_centi;
    end
  end

  wbfb_eval u_eval (
    .clk               (clk),
    .rst_n             (rst_n),
    .take              (take),
    .pulse_count       (count_r),
    .batt_level        (batt_r),
    .temp_centi        (temp_r),
    .tick_seconds      (tick_r),
    .heartbeat_seconds (hb_r),
    .speed_scale       (scale_r),
    .emit              (emit),
    .frame             (frame)
  );

  wbfb_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take && emit),
    .frame      (frame),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (out_frame_byte),
    .byte_index (out_byte_index),
    .last_byte  (out_last_byte)
  );

endmodule

/* tb/sv/wind_beacon_frame_builder_tb.sv */
// ---------------------------------------------------------------------------
// wind_beacon_frame_builder_tb
// self-checking bench for the wake-tick beacon encoder: ticks are driven on
// the input channel, a predictor works out every advertisement byte on each
// accepted tick and the monitor compares each output transfer in order
// ---------------------------------------------------------------------------
module wind_beacon_frame_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_SPARE   = 2'd3;
  localparam int         SETTLE_CYC  = 8;
  localparam int         HOLD_CYC    = 400;
  localparam int         STALL_LIMIT = 2000;
  localparam int         REPORT_CAP  = 40;

  typedef struct {
    logic [31:0] count;
    logic [6:0]  batt;
    logic [15:0] temp;
  } tick_t;

  typedef struct {
    logic [7:0] data;
    logic [4:0] idx;
    logic       last;
  } adv_byte_t;

  logic        clk;
  logic        rst_n              = 1'b0;
  logic        cfg_we             = 1'b0;
  logic [1:0]  cfg_index          = wbfb_pkg::REG_TICK;
  logic [23:0] cfg_data           = '0;
  logic        in_valid           = 1'b0;
  logic        in_ready;
  logic [31:0] in_pulse_count     = '0;
  logic [6:0]  in_batt_level      = '0;
  logic signed [15:0] in_temp_centi = '0;
  logic        out_valid;
  logic        out_ready          = 1'b0;
  logic [7:0]  out_frame_byte;
  logic [4:0]  out_byte_index;
  logic        out_last_byte;

  wind_beacon_frame_builder uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_pulse_count     (in_pulse_count),
    .in_batt_level      (in_batt_level),
    .in_temp_centi      (in_temp_centi),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame_byte     (out_frame_byte),
    .out_byte_index     (out_byte_index),
    .out_last_byte      (out_last_byte)
  );

  // configuration as the block should hold it
  logic [11:0] tick_len_s   = 12'd5;
  logic [15:0] heartbeat_s  = 16'd60;
  logic [23:0] speed_factor = 24'd802960;

  // beacon state
  logic        have_baseline = 1'b0;
  logic [31:0] baseline_cnt  = '0;
  logic [16:0] since_adv_s   = '0;
  logic [31:0] adv_delta     = '0;
  logic [7:0]  next_pkt_id   = '0;

  tick_t       tick_q[$];
  tick_t       tick_on_bus;
  adv_byte_t   adv_byte_q[$];
  int unsigned ticks_queued   = 0;
  int unsigned ticks_accepted = 0;
  int unsigned mismatches     = 0;
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_idle_pct    = 0;
  logic        rx_hold_start  = 1'b0;
  int unsigned rx_hold_left   = 0;
  int unsigned stall_cycles   = 0;

  // wind model for random ticks
  logic [31:0] wind_count = '0;
  logic [31:0] wind_step  = 32'd7;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < REPORT_CAP) begin
      $display("%0t ns mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic void beacon_predict(input tick_t t);
    logic [31:0] delta;
    logic [63:0] scaled;
    logic [15:0] speed;
    logic [7:0]  fr [wbfb_pkg::FRAME_LEN];
    if (!have_baseline) begin
      have_baseline = 1'b1;
      baseline_cnt  = t.count;
      since_adv_s   = '0;
      adv_delta     = '0;
      next_pkt_id   = '0;
    end
    since_adv_s = 17'(since_adv_s + {5'd0, tick_len_s});
    delta = t.count - baseline_cnt;
    if (delta == adv_delta && since_adv_s < {1'b0, heartbeat_s}) begin
      return;
    end
    scaled = ({32'd0, delta} * {40'd0, speed_factor} + 64'd32768) >> 16;
    speed  = (scaled > 64'hFFFF) ? 16'hFFFF : scaled[15:0];
    fr[0]  = wbfb_pkg::AD_FLAGS_LEN;
    fr[1]  = wbfb_pkg::AD_FLAGS_TYPE;
    fr[2]  = wbfb_pkg::AD_FLAGS_VAL;
    fr[3]  = wbfb_pkg::AD_SVC_LEN;
    fr[4]  = wbfb_pkg::AD_SVC_TYPE;
    fr[5]  = wbfb_pkg::UUID_LO;
    fr[6]  = wbfb_pkg::UUID_HI;
    fr[7]  = wbfb_pkg::DEV_INFO;
    fr[8]  = wbfb_pkg::OBJ_PID;
    fr[9]  = next_pkt_id;
    fr[10] = wbfb_pkg::OBJ_BATT;
    fr[11] = {1'b0, t.batt};
    fr[12] = wbfb_pkg::OBJ_TEMP;
    fr[13] = t.temp[7:0];
    fr[14] = t.temp[15:8];
    fr[15] = wbfb_pkg::OBJ_SPEED;
    fr[16] = speed[7:0];
    fr[17] = speed[15:8];
    fr[18] = wbfb_pkg::NAME_LEN;
    fr[19] = wbfb_pkg::NAME_TYPE;
    for (int i = 0; i < 11; i++) begin
      fr[20 + i] = wbfb_pkg::NAME_BYTES[i];
    end
    for (int i = 0; i < wbfb_pkg::FRAME_LEN; i++) begin
      adv_byte_q.push_back('{fr[i], 5'(i), 1'(i == wbfb_pkg::FRAME_LEN - 1)});
    end
    next_pkt_id  = next_pkt_id + 8'd1;
    baseline_cnt = t.count;
    adv_delta    = delta;
    since_adv_s  = '0;
  endfunction

  function automatic void push_tick(input logic [31:0] count, input logic [6:0] batt,
                                    input logic [15:0] temp);
    tick_q.push_back('{count, batt, temp});
    ticks_queued++;
  endfunction

  function automatic void push_random_tick();
    int unsigned pick;
    logic [6:0]  batt;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      wind_count = wind_count + wind_step;
    end else if (pick < 85) begin
      wind_step  = $urandom_range(0, 50);
      wind_count = wind_count + wind_step;
    end else if (pick < 93) begin
      // counter glitch
      wind_count = $urandom;
    end else begin
      wind_count = wind_count + $urandom;
    end
    if ($urandom_range(0, 9) == 0) begin
      batt = 7'($urandom_range(101, 127));
    end else begin
      batt = 7'($urandom_range(0, 100));
    end
    push_tick(wind_count, batt, 16'($urandom));
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      wbfb_pkg::REG_TICK:      tick_len_s   = val[11:0];
      wbfb_pkg::REG_HEARTBEAT: heartbeat_s  = val[15:0];
      wbfb_pkg::REG_SCALE:     speed_factor = val;
      default: ;
    endcase
  endtask

  // all ticks taken, all bytes out, then room for a silent tick to retire
  task automatic wait_idle();
    while (ticks_accepted != ticks_queued || adv_byte_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        beacon_predict(tick_on_bus);
        ticks_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (tick_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          tick_on_bus     = tick_q.pop_front();
          in_pulse_count <= tick_on_bus.count;
          in_batt_level  <= tick_on_bus.batt;
          in_temp_centi  <= tick_on_bus.temp;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready    <= 1'b0;
      rx_hold_left <= 0;
    end else if (rx_hold_start) begin
      out_ready    <= 1'b0;
      rx_hold_left <= HOLD_CYC;
    end else if (rx_hold_left != 0) begin
      out_ready    <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    adv_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (adv_byte_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer byte %02h idx %0d",
                                  out_frame_byte, out_byte_index));
      end else begin
        want = adv_byte_q.pop_front();
        if (out_frame_byte !== want.data) begin
          report_mismatch($sformatf("frame_byte idx %0d: got %02h want %02h",
                                    want.idx, out_frame_byte, want.data));
        end
        if (out_byte_index !== want.idx) begin
          report_mismatch($sformatf("byte_index: got %0d want %0d",
                                    out_byte_index, want.idx));
        end
        if (out_last_byte !== want.last) begin
          report_mismatch($sformatf("last_byte idx %0d: got %b want %b",
                                    want.idx, out_last_byte, want.last));
        end
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("wind_beacon_frame_builder_tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    tx_idle_pct = 38;
    rx_idle_pct = 50;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // heartbeat equal to tick length: the very first tick advertises
    write_reg(wbfb_pkg::REG_HEARTBEAT, 24'd5);
    push_tick(32'hFFFF_FFF0, 7'd0,   16'h8000);
    push_tick(32'hFFFF_FFF0, 7'd100, 16'h7FFF);
    push_tick(32'h0000_0005, 7'd101, 16'hFFFF);
    push_tick(32'h0000_0005, 7'd127, 16'h0000);
    push_tick(32'hFFFF_FFFF, 7'd64,  16'h00FF);
    push_tick(32'h0000_0000, 7'd63,  16'hFF00);
    wait_idle();

    // default rate, junk above the tick field
    write_reg(wbfb_pkg::REG_TICK, 24'hFFF005);
    write_reg(wbfb_pkg::REG_HEARTBEAT, 24'd60);
    write_reg(wbfb_pkg::REG_SCALE, 24'd802960);
    push_tick(32'd100, 7'd50, 16'd2150);
    push_tick(32'd200, 7'd50, 16'd2150);
    push_tick(32'd300, 7'd51, 16'd2150);
    push_tick(32'd301, 7'd51, 16'hF830);
    push_tick(32'd302, 7'd52, 16'hF830);
    push_tick(32'd302 + 32'h1_0000, 7'd52, 16'd1);
    push_tick(32'd302 + 32'h1_0000, 7'd53, 16'd1);
    wait_idle();

    // zero tick and zero heartbeat, half-step scale for rounding
    write_reg(wbfb_pkg::REG_TICK, 24'd0);
    write_reg(wbfb_pkg::REG_HEARTBEAT, 24'd0);
    write_reg(wbfb_pkg::REG_SCALE, 24'd32768);
    write_reg(REG_SPARE, 24'hFFFFFF);
    push_tick(32'd1000, 7'd10, 16'd0);
    push_tick(32'd1000, 7'd10, 16'd0);
    push_tick(32'd1001, 7'd11, 16'd0);
    push_tick(32'd1003, 7'd12, 16'd0);
    push_tick(32'd1006, 7'd13, 16'd0);
    push_tick(32'd1005, 7'd14, 16'd0);
    wait_idle();

    // random, default rates, with a sender pause mid-way
    wind_count = $urandom;
    write_reg(wbfb_pkg::REG_TICK, 24'd5);
    write_reg(wbfb_pkg::REG_HEARTBEAT, 24'd60);
    write_reg(wbfb_pkg::REG_SCALE, 24'd802960);
    repeat (40) push_random_tick();
    wait_idle();
    repeat (40) push_random_tick();
    wait_idle();

    tx_idle_pct = 50;
    rx_idle_pct = 38;
    write_reg(wbfb_pkg::REG_TICK, 24'd4095);
    write_reg(wbfb_pkg::REG_HEARTBEAT, 24'd65535);
    write_reg(wbfb_pkg::REG_SCALE, 24'hFFFFFF);
    repeat (60) push_random_tick();
    wait_idle();

    // every tick advertises while the receiver holds off
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(wbfb_pkg::REG_TICK, 24'd1);
    write_reg(wbfb_pkg::REG_HEARTBEAT, 24'd0);
    write_reg(wbfb_pkg::REG_SCALE, 24'd0);
    repeat (120) push_random_tick();
    rx_hold_start <= 1'b1;
    @(posedge clk);
    rx_hold_start <= 1'b0;
    wait_idle();

    write_reg(wbfb_pkg::REG_TICK, 24'($urandom_range(1, 3600)));
    write_reg(wbfb_pkg::REG_HEARTBEAT, 24'($urandom_range(0, 60)));
    write_reg(wbfb_pkg::REG_SCALE, 24'($urandom));
    repeat (50) push_random_tick();
    wait_idle();

    if (adv_byte_q.size() != 0) begin
      report_mismatch($sformatf("%0d bytes never arrived", adv_byte_q.size()));
    end
    if (mismatches == 0) begin
      $display("wind_beacon_frame_builder_tb: PASS");
    end else begin
      $display("wind_beacon_frame_builder_tb: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/wbfb_pkg.sv
rtl/core/wbfb_eval.sv
rtl/core/wbfb_serializer.sv
rtl/core/wind_beacon_frame_builder.sv
tb/sv/wind_beacon_frame_builder_tb.sv
